### rtl/pcf_pkg.sv
// Shared types, constants and a helper function of the pixel color filter.
package pcf_pkg;

  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int NUM_LANES   = 3;
  localparam int LANE_STAGES = 4;
  localparam int PIPE_STAGES = LANE_STAGES + 2;

  // Lane positions in the lane array.
  localparam int LANE_BLUE  = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_RED   = 2;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [2:0] REG_TONE_BLUE     = 3'd1;
  localparam logic [2:0] REG_TONE_GREEN    = 3'd2;
  localparam logic [2:0] REG_TONE_RED      = 3'd3;
  localparam logic [2:0] REG_TONE_STRENGTH = 3'd4;

  // Luma weights in thousandths.
  localparam logic [9:0] LUMA_W_BLUE  = 10'd114;
  localparam logic [9:0] LUMA_W_GREEN = 10'd587;
  localparam logic [9:0] LUMA_W_RED   = 10'd299;

  // Reciprocals: floor(x * RECIP >> SHIFT) equals floor(x / divisor) over the
  // value range that each one is used on.
  localparam logic [48:0] RECIP_255  = 49'd16843010;   // ceil(2^32 / 255)
  localparam logic [19:0] RECIP_3    = 20'd683;        // ceil(2^11 / 3)
  localparam logic [36:0] RECIP_1000 = 37'd268436;     // ceil(2^28 / 1000)

  typedef enum logic [2:0] {
    MODE_NEGATIVE = 3'd0,
    MODE_AVERAGE  = 3'd1,
    MODE_LUMA     = 3'd2,
    MODE_DESAT    = 3'd3,
    MODE_BLUE     = 3'd4,
    MODE_GREEN    = 3'd5,
    MODE_RED      = 3'd6,
    MODE_TONING   = 3'd7
  } filter_mode_t;

  typedef struct packed {
    filter_mode_t mode;
    logic [7:0]   tone_blue;
    logic [7:0]   tone_green;
    logic [7:0]   tone_red;
    logic [7:0]   tone_strength;
  } cfg_t;

  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
  } lane_en_t;

  typedef struct packed {
    logic load_sum;
    logic load_out;
  } merge_en_t;

  typedef struct packed {
    logic [7:0]  chan;
    logic [17:0] weighted;
    logic [7:0]  toned;
  } lane_out_t;

  // Exact floor(x / 255) for x up to 65025.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] tmp;
    tmp = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return tmp[15:8];
  endfunction

endpackage

### rtl/pcf_regs.sv
// Configuration registers behind the APB-style port.
module pcf_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pcf_pkg::ADDR_W-1:0] paddr,
  input  logic [pcf_pkg::DATA_W-1:0] pwdata,
  output logic [pcf_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output pcf_pkg::cfg_t              cfg
);

  logic [2:0] index;
  logic       write;

  assign index  = paddr[pcf_pkg::ADDR_W-1:2];
  assign write  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= pcf_pkg::MODE_AVERAGE;
      cfg.tone_blue     <= 8'd0;
      cfg.tone_green    <= 8'd0;
      cfg.tone_red      <= 8'd0;
      cfg.tone_strength <= 8'd0;
    end else if (write) begin
      case (index)
        pcf_pkg::REG_FILTER_MODE:   cfg.mode <= pcf_pkg::filter_mode_t'(pwdata[2:0]);
        pcf_pkg::REG_TONE_BLUE:     cfg.tone_blue <= pwdata[7:0];
        pcf_pkg::REG_TONE_GREEN:    cfg.tone_green <= pwdata[7:0];
        pcf_pkg::REG_TONE_RED:      cfg.tone_red <= pwdata[7:0];
        pcf_pkg::REG_TONE_STRENGTH: cfg.tone_strength <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (index)
      pcf_pkg::REG_FILTER_MODE:   prdata = {29'd0, cfg.mode};
      pcf_pkg::REG_TONE_BLUE:     prdata = {24'd0, cfg.tone_blue};
      pcf_pkg::REG_TONE_GREEN:    prdata = {24'd0, cfg.tone_green};
      pcf_pkg::REG_TONE_RED:      prdata = {24'd0, cfg.tone_red};
      pcf_pkg::REG_TONE_STRENGTH: prdata = {24'd0, cfg.tone_strength};
      default:                    prdata = '0;
    endcase
  end

endmodule

### rtl/pcf_lane.sv
// One color channel lane: luma weighting and the toning arithmetic.
module pcf_lane (
  input  logic                clk,
  input  pcf_pkg::lane_en_t   en,
  input  logic [7:0]          chan,
  input  logic [7:0]          tone,
  input  logic [7:0]          strength,
  input  logic [9:0]          weight,
  output pcf_pkg::lane_out_t  result
);

  // Stage 1
  logic [7:0]  c1;
  logic [7:0]  t1;
  logic [15:0] ca1;
  logic [17:0] wc1;
  // Stage 2
  logic [7:0]  c2;
  logic [17:0] wc2;
  logic [23:0] cat2;
  logic [7:0]  dv2;
  // Stage 3
  logic [7:0]  c3;
  logic [17:0] wc3;
  logic [7:0]  dv3;
  logic [15:0] q3;
  // Stage 4
  logic [7:0]  c4;
  logic [17:0] wc4;
  logic [7:0]  toned4;

  logic [48:0] recip_prod;
  logic [8:0]  tone_sum;

  assign recip_prod = {25'd0, cat2} * pcf_pkg::RECIP_255;
  assign tone_sum   = {1'b0, pcf_pkg::div255(q3)} + {1'b0, c3} - {1'b0, dv3};

  always_ff @(posedge clk) begin
    if (en.load[0]) begin
      c1  <= chan;
      t1  <= tone;
      ca1 <= {8'd0, chan} * {8'd0, strength};
      wc1 <= {10'd0, chan} * {8'd0, weight};
    end
    if (en.load[1]) begin
      c2   <= c1;
      wc2  <= wc1;
      cat2 <= {8'd0, ca1} * {16'd0, t1};
      dv2  <= pcf_pkg::div255(ca1);
    end
    if (en.load[2]) begin
      c3  <= c2;
      wc3 <= wc2;
      dv3 <= dv2;
      // c*a*t/255, later divided by 255 once more: nested floors are exact.
      q3  <= recip_prod[47:32];
    end
    if (en.load[3]) begin
      c4     <= c3;
      wc4    <= wc3;
      toned4 <= tone_sum[7:0];
    end
  end

  assign result.chan     = c4;
  assign result.weighted = wc4;
  assign result.toned    = toned4;

endmodule

### rtl/pcf_merge.sv
// Merging stages: grayscale values from all lanes and the mode select.
module pcf_merge (
  input  logic                clk,
  input  pcf_pkg::merge_en_t  en,
  input  pcf_pkg::filter_mode_t mode,
  input  pcf_pkg::lane_out_t  lanes [pcf_pkg::NUM_LANES],
  output logic [7:0]          out_blue,
  output logic [7:0]          out_green,
  output logic [7:0]          out_red
);

  logic [7:0]  b5, g5, r5;
  logic [7:0]  tb5, tg5, tr5;
  logic [9:0]  sum5;
  logic [17:0] luma5;
  logic [7:0]  lo5, hi5;

  logic [7:0]  b, g, r;
  logic [7:0]  lo_bg, hi_bg;
  logic [19:0] avg_prod;
  logic [36:0] luma_prod;
  logic [8:0]  desat_sum;
  logic [7:0]  ob, og, orr;

  assign b = lanes[pcf_pkg::LANE_BLUE].chan;
  assign g = lanes[pcf_pkg::LANE_GREEN].chan;
  assign r = lanes[pcf_pkg::LANE_RED].chan;

  assign lo_bg = (b < g) ? b : g;
  assign hi_bg = (b > g) ? b : g;

  always_ff @(posedge clk) begin
    if (en.load_sum) begin
      b5    <= b;
      g5    <= g;
      r5    <= r;
      tb5   <= lanes[pcf_pkg::LANE_BLUE].toned;
      tg5   <= lanes[pcf_pkg::LANE_GREEN].toned;
      tr5   <= lanes[pcf_pkg::LANE_RED].toned;
      sum5  <= {2'd0, b} + {2'd0, g} + {2'd0, r};
      luma5 <= lanes[pcf_pkg::LANE_BLUE].weighted + lanes[pcf_pkg::LANE_GREEN].weighted
             + lanes[pcf_pkg::LANE_RED].weighted;
      lo5   <= (lo_bg < r) ? lo_bg : r;
      hi5   <= (hi_bg > r) ? hi_bg : r;
    end
  end

  assign avg_prod  = {10'd0, sum5} * pcf_pkg::RECIP_3;
  assign luma_prod = {19'd0, luma5} * pcf_pkg::RECIP_1000;
  assign desat_sum = {1'b0, lo5} + {1'b0, hi5};

  always_comb begin
    case (mode)
      pcf_pkg::MODE_NEGATIVE: begin
        ob = ~b5; og = ~g5; orr = ~r5;
      end
      pcf_pkg::MODE_AVERAGE: begin
        ob = avg_prod[18:11]; og = avg_prod[18:11]; orr = avg_prod[18:11];
      end
      pcf_pkg::MODE_LUMA: begin
        ob = luma_prod[35:28]; og = luma_prod[35:28]; orr = luma_prod[35:28];
      end
      pcf_pkg::MODE_DESAT: begin
        ob = desat_sum[8:1]; og = desat_sum[8:1]; orr = desat_sum[8:1];
      end
      pcf_pkg::MODE_BLUE: begin
        ob = b5; og = b5; orr = b5;
      end
      pcf_pkg::MODE_GREEN: begin
        ob = g5; og = g5; orr = g5;
      end
      pcf_pkg::MODE_RED: begin
        ob = r5; og = r5; orr = r5;
      end
      pcf_pkg::MODE_TONING: begin
        ob = tb5; og = tg5; orr = tr5;
      end
      default: begin
        ob = tb5; og = tg5; orr = tr5;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.load_out) begin
      out_blue  <= ob;
      out_green <= og;
      out_red   <= orr;
    end
  end

endmodule

### rtl/pixel_color_filter.sv
// Top level of the pixel color filter: stage control and lane instances.
//
//   port group        direction  handshake            carries
//   in_*              in         in_valid / in_ready  in_blue, in_green, in_red, end_of_image
//   out_*             out        out_valid / out_ready out_blue, out_green, out_red,
//                                                     end_of_image_out
//   p*                in/out     APB-style, pready=1  filter_mode, tone color, tone strength
//
// One pixel request is taken every clock while in_ready is high; it passes six register
// stages, the last of them the output register. The stages are four lane stages (two
// chained multiplies, a reciprocal divide by 255 and the tone sum) and two merge
// stages (sum, then divide and select).
// Reset clears all stage valid bits and loads the register defaults.
// A stall on the output holds the last stage; earlier stages keep moving until
// they fill, so bubbles are squeezed out and no request is lost.
module pixel_color_filter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_blue,
  input  logic [7:0]                 in_green,
  input  logic [7:0]                 in_red,
  input  logic                       end_of_image,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_red,
  output logic                       end_of_image_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pcf_pkg::ADDR_W-1:0] paddr,
  input  logic [pcf_pkg::DATA_W-1:0] pwdata,
  output logic [pcf_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  pcf_pkg::cfg_t      cfg;
  pcf_pkg::lane_en_t  lane_en;
  pcf_pkg::merge_en_t merge_en;
  pcf_pkg::lane_out_t lane_out [pcf_pkg::NUM_LANES];

  logic [pcf_pkg::PIPE_STAGES-1:0] stage_valid;
  logic [pcf_pkg::PIPE_STAGES-1:0] stage_ready;
  logic [pcf_pkg::PIPE_STAGES-1:0] eoi;

  // A stage may load when it is empty or when its content moves on.
  always_comb begin
    stage_ready[pcf_pkg::PIPE_STAGES-1] = !stage_valid[pcf_pkg::PIPE_STAGES-1] || out_ready;
    for (int k = pcf_pkg::PIPE_STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < pcf_pkg::PIPE_STAGES; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[0]) begin
      eoi[0] <= end_of_image;
    end
    for (int k = 1; k < pcf_pkg::PIPE_STAGES; k++) begin
      if (stage_ready[k]) begin
        eoi[k] <= eoi[k-1];
      end
    end
  end

  assign lane_en.load     = stage_ready[pcf_pkg::LANE_STAGES-1:0];
  assign merge_en.load_sum = stage_ready[pcf_pkg::LANE_STAGES];
  assign merge_en.load_out = stage_ready[pcf_pkg::LANE_STAGES+1];

  assign in_ready         = stage_ready[0];
  assign out_valid        = stage_valid[pcf_pkg::PIPE_STAGES-1];
  assign end_of_image_out = eoi[pcf_pkg::PIPE_STAGES-1];

  pcf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcf_lane u_lane_blue (
    .clk      (clk),
    .en       (lane_en),
    .chan     (in_blue),
    .tone     (cfg.tone_blue),
    .strength (cfg.tone_strength),
    .weight   (pcf_pkg::LUMA_W_BLUE),
    .result   (lane_out[pcf_pkg::LANE_BLUE])
  );

  pcf_lane u_lane_green (
    .clk      (clk),
    .en       (lane_en),
    .chan     (in_green),
    .tone     (cfg.tone_green),
    .strength (cfg.tone_strength),
    .weight   (pcf_pkg::LUMA_W_GREEN),
    .result   (lane_out[pcf_pkg::LANE_GREEN])
  );

  pcf_lane u_lane_red (
    .clk      (clk),
    .en       (lane_en),
    .chan     (in_red),
    .tone     (cfg.tone_red),
    .strength (cfg.tone_strength),
    .weight   (pcf_pkg::LUMA_W_RED),
    .result   (lane_out[pcf_pkg::LANE_RED])
  );

  pcf_merge u_merge (
    .clk       (clk),
    .en        (merge_en),
    .mode      (cfg.mode),
    .lanes     (lane_out),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red)
  );

endmodule
